>>> rtl/mlr_pkg.sv
// Package for the midpoint line rasterizer: coordinate and decision widths,
// the octant codes, the beat structs of both channels and the line state.
// No dependencies.
`default_nettype none

package mlr_pkg;

  localparam int unsigned CoordBits = 10;
  localparam int unsigned DecBits   = CoordBits + 4;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  typedef enum logic [1:0] {
    OCT_SHALLOW_RISE = 2'd0,
    OCT_STEEP_RISE   = 2'd1,
    OCT_SHALLOW_FALL = 2'd2,
    OCT_STEEP_FALL   = 2'd3
  } octant_e;

  typedef logic [CoordBits-1:0] coord_t;

  typedef struct packed {
    logic   req_type;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
  } in_beat_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;
  } out_beat_t;

  typedef struct packed {
    coord_t                    cur_x;
    coord_t                    cur_y;
    coord_t                    fin_x;
    coord_t                    fin_y;
    coord_t                    span_x;
    coord_t                    span_y_abs;
    logic signed [DecBits-1:0] decision;
    octant_e                   octant;
    logic                      drawing;
  } line_state_t;

endpackage

`default_nettype wire

>>> rtl/mlr_core.sv
// Combinational datapath of the midpoint line rasterizer: line setup on a
// load beat and one decision step on a step beat. Uses mlr_pkg.
`default_nettype none

module mlr_core import mlr_pkg::*; (
  input  line_state_t state_i,
  input  in_beat_t    beat_i,
  output line_state_t state_o,
  output out_beat_t   pixel_o,
  output logic        emit_o
);

  coord_t                  sx, sy, ex, ey;
  logic                    swap;
  logic signed [CoordBits:0] dy;
  coord_t                  dy_abs;
  coord_t                  dx;
  logic                    steep;
  logic signed [DecBits-1:0] dy_ext, dx_ext, a2, x2, dec_nx;
  logic                    pos;
  coord_t                  nx, ny;
  logic                    step_last;

  always_comb begin
    swap = (beat_i.x_start > beat_i.x_end) ||
           ((beat_i.x_start == beat_i.x_end) && (beat_i.y_start > beat_i.y_end));
    sx = swap ? beat_i.x_end   : beat_i.x_start;
    sy = swap ? beat_i.y_end   : beat_i.y_start;
    ex = swap ? beat_i.x_start : beat_i.x_end;
    ey = swap ? beat_i.y_start : beat_i.y_end;
    dx = ex - sx;
    dy = $signed({1'b0, ey}) - $signed({1'b0, sy});
    dy_abs = dy[CoordBits] ? coord_t'(-dy) : dy[CoordBits-1:0];
    steep = dy_abs > dx;
    dy_ext = $signed({{(DecBits-CoordBits-1){dy[CoordBits]}}, dy});
    dx_ext = $signed({{(DecBits-CoordBits){1'b0}}, dx});
  end

  always_comb begin
    a2 = $signed({{(DecBits-CoordBits-1){1'b0}}, state_i.span_y_abs, 1'b0});
    x2 = $signed({{(DecBits-CoordBits-1){1'b0}}, state_i.span_x, 1'b0});
    pos = !state_i.decision[DecBits-1];
    nx = state_i.cur_x;
    ny = state_i.cur_y;
    dec_nx = state_i.decision;
    case (state_i.octant)
      OCT_SHALLOW_RISE: begin
        dec_nx = pos ? state_i.decision + a2 - x2 : state_i.decision + a2;
        ny = pos ? state_i.cur_y + coord_t'(1) : state_i.cur_y;
        nx = state_i.cur_x + coord_t'(1);
      end
      OCT_STEEP_RISE: begin
        dec_nx = pos ? state_i.decision - x2 : state_i.decision + a2 - x2;
        nx = pos ? state_i.cur_x : state_i.cur_x + coord_t'(1);
        ny = state_i.cur_y + coord_t'(1);
      end
      OCT_SHALLOW_FALL: begin
        dec_nx = pos ? state_i.decision - a2 : state_i.decision + x2 - a2;
        ny = pos ? state_i.cur_y : state_i.cur_y - coord_t'(1);
        nx = state_i.cur_x + coord_t'(1);
      end
      OCT_STEEP_FALL: begin
        dec_nx = pos ? state_i.decision + x2 - a2 : state_i.decision + x2;
        nx = pos ? state_i.cur_x + coord_t'(1) : state_i.cur_x;
        ny = state_i.cur_y - coord_t'(1);
      end
      default: begin
        dec_nx = state_i.decision;
      end
    endcase
    step_last = state_i.octant[0] ? (ny == state_i.fin_y) : (nx == state_i.fin_x);
  end

  always_comb begin
    state_o = state_i;
    pixel_o = '0;
    emit_o  = 1'b0;
    if (beat_i.req_type == REQ_LOAD) begin
      state_o.cur_x      = sx;
      state_o.cur_y      = sy;
      state_o.fin_x      = ex;
      state_o.fin_y      = ey;
      state_o.span_x     = dx;
      state_o.span_y_abs = dy_abs;
      if (!dy[CoordBits]) begin
        state_o.octant   = steep ? OCT_STEEP_RISE : OCT_SHALLOW_RISE;
        state_o.decision = steep ? dy_ext - (dx_ext <<< 1) : (dy_ext <<< 1) - dx_ext;
      end else begin
        state_o.octant   = steep ? OCT_STEEP_FALL : OCT_SHALLOW_FALL;
        state_o.decision = steep ? dy_ext + (dx_ext <<< 1) : (dy_ext <<< 1) + dx_ext;
      end
      pixel_o.pixel_x    = sx;
      pixel_o.pixel_y    = sy;
      pixel_o.last_pixel = steep ? (sy == ey) : (sx == ex);
      state_o.drawing    = !pixel_o.last_pixel;
      emit_o             = 1'b1;
    end else if (state_i.drawing) begin
      state_o.cur_x      = nx;
      state_o.cur_y      = ny;
      state_o.decision   = dec_nx;
      state_o.drawing    = !step_last;
      pixel_o.pixel_x    = nx;
      pixel_o.pixel_y    = ny;
      pixel_o.last_pixel = step_last;
      emit_o             = 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/midpoint_line_rasterizer.sv
// Midpoint line rasterizer top level: line state and result registers
// around the mlr_core datapath. Uses mlr_pkg and mlr_core.
//
// Usage: send a load beat (req_type = 0) with two endpoints; it yields the
// first pixel of the line. Each step beat (req_type = 1) yields the next
// pixel; the final pixel carries last_pixel = 1 and the block goes idle.
// A step beat while idle is taken and yields no pixel. A load beat while a
// line is in progress abandons that line.
// Input channel: in_valid_i / in_stall_o / in_data_i. Output channel:
// out_valid_o / out_stall_i / out_data_o.
// Output: a pixel is registered, shown the cycle after its beat is taken.
// Throughput: one beat per cycle unless stalled; each step is a short add
// chain on the decision value, between the state and result registers.
// Stall: a held pixel stays in the result register while out_stall_i is
// high, and the input is stalled only while a held pixel waits.
// Reset: rst_ni clears the line state to zero and idle and empties the
// result register.
`default_nettype none

module midpoint_line_rasterizer import mlr_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_beat_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_beat_t      out_data_o
);

  line_state_t state_q, state_d;
  out_beat_t   pix_d, out_data_q;
  logic        emit_d, out_valid_q;
  logic        in_acc;

  mlr_core u_core (
    .state_i (state_q),
    .beat_i  (in_data_i),
    .state_o (state_d),
    .pixel_o (pix_d),
    .emit_o  (emit_d)
  );

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      state_q     <= state_d;
      out_valid_q <= emit_d;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= pix_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

>>> rtl/mlr_checker.sv
// Port-level checker for the midpoint line rasterizer and its bind to the
// top level. Uses mlr_pkg.
`default_nettype none

module mlr_checker import mlr_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire in_beat_t  in_data_i,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_beat_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("pixel dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled pixel changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held pixel");

  a_load_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.req_type == REQ_LOAD) |=> out_valid_o)
    else $error("load beat gave no pixel");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_valid_i && !in_stall_o) && !out_stall_i |=> !out_valid_o)
    else $error("pixel without an accepted beat");

endmodule

bind midpoint_line_rasterizer mlr_checker u_mlr_checker (.*);

`default_nettype wire
